// ----- rtl/gda_pkg.sv -----
// Shared types, calendar constants and lookup functions for the date adder.
`timescale 1ns / 1ps

package gda_pkg;

  localparam int YEAR_W  = 14;
  localparam int MONTH_W = 4;
  localparam int DAY_W   = 5;
  localparam int DOY_W   = 9;

  localparam logic [YEAR_W-1:0]  YEAR_FIRST = 14'd1;
  localparam logic [YEAR_W-1:0]  YEAR_LAST  = 14'd9999;
  localparam logic [MONTH_W-1:0] MONTH_JAN  = 4'd1;
  localparam logic [MONTH_W-1:0] MONTH_FEB  = 4'd2;
  localparam logic [MONTH_W-1:0] MONTH_DEC  = 4'd12;
  localparam logic [DAY_W-1:0]   DAY_FIRST  = 5'd1;
  localparam logic [DAY_W-1:0]   DAY_LAST   = 5'd31;
  localparam logic [DOY_W-1:0]   YEAR_DAYS  = 9'd365;

  // Year counter controls.
  typedef struct packed {
    logic              load;
    logic              inc;
    logic              dec;
    logic [YEAR_W-1:0] year;
  } gda_yctl_t;

  // Year counter status.
  typedef struct packed {
    logic [YEAR_W-1:0] year;
    logic              leap;
  } gda_ystat_t;

  function automatic logic [DAY_W-1:0] days_in(input logic leap, input logic [MONTH_W-1:0] m);
    logic [DAY_W-1:0] n;
    case (m)
      4'd2:                      n = leap ? 5'd29 : 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11:   n = 5'd30;
      default:                   n = 5'd31;
    endcase
    return n;
  endfunction

  function automatic logic [DOY_W-1:0] month_start(input logic [MONTH_W-1:0] m);
    logic [DOY_W-1:0] s;
    case (m)
      4'd2:    s = 9'd31;
      4'd3:    s = 9'd59;
      4'd4:    s = 9'd90;
      4'd5:    s = 9'd120;
      4'd6:    s = 9'd151;
      4'd7:    s = 9'd181;
      4'd8:    s = 9'd212;
      4'd9:    s = 9'd243;
      4'd10:   s = 9'd273;
      4'd11:   s = 9'd304;
      4'd12:   s = 9'd334;
      default: s = 9'd0;
    endcase
    return s;
  endfunction

endpackage

// ----- rtl/gregorian_date_add_days_top.sv -----
// Top level of the Gregorian date adder: command port, sequencer and result registers.
`timescale 1ns / 1ps

// Adds a signed day offset to a Gregorian date and returns the date that many
// days away, proleptic Gregorian, 0001-01-01 to 9999-12-31. Raise start while
// busy is low to transfer a date and offset; busy stays high until the result
// appears. The result shows on the out_ ports for exactly one cycle, marked by
// out_valid, and cannot be held off, so capture it on that cycle. An out-of-
// range input year, month or day is first clamped (year to 1..9999, month to
// 1..12, day to 1..length of month). A result outside 1..9999 saturates to the
// nearest end date and raises out_out_of_range. An item runs in this order:
// ST_SET1 and ST_SET2 settle the leap tracker and ST_DOY folds the offset
// into a day of the year; ST_YEAR steps the year (forward in ST_YEAR alone,
// backward through ST_YEAR and ST_YADD, at most about 180 years either way
// for a 17-bit offset) and then leaves the year loop; ST_MONTH makes the
// month steps (at most 11) and picks the day; the result registers present
// the result. A saturated result leaves straight from the year loop and skips
// the month walk. Busy drops as the result appears, so the next start can
// transfer during the result cycle. A single add/subtract unit does every
// year and month step, so the year loop sets the latency.
module gregorian_date_add_days_top
  import gda_pkg::*;
#(
  parameter int OFFSET_BITS = 17
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   start,
  output logic                   busy,
  input  logic [YEAR_W-1:0]      in_start_year,
  input  logic [MONTH_W-1:0]     in_start_month,
  input  logic [DAY_W-1:0]       in_start_day,
  input  logic [OFFSET_BITS-1:0] in_day_offset,
  output logic                   out_valid,
  output logic [YEAR_W-1:0]      out_result_year,
  output logic [MONTH_W-1:0]     out_result_month,
  output logic [DAY_W-1:0]       out_result_day,
  output logic                   out_out_of_range
);

  // Day position within the year plus offset; headroom for a year of days.
  localparam int TW = ((OFFSET_BITS > 10) ? OFFSET_BITS : 10) + 1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SET1,
    ST_SET2,
    ST_DOY,
    ST_YEAR,
    ST_YADD,
    ST_MONTH
  } state_t;

  state_t                  state_r, state_nxt;
  logic [MONTH_W-1:0]      mon_r, mon_nxt;
  logic [DAY_W-1:0]        day_r, day_nxt;
  logic [OFFSET_BITS-1:0]  off_r, off_nxt;
  logic signed [TW-1:0]    t_r, t_nxt;
  logic                    valid_r, valid_nxt;
  logic [YEAR_W-1:0]       ry_r, ry_nxt;
  logic [MONTH_W-1:0]      rm_r, rm_nxt;
  logic [DAY_W-1:0]        rd_r, rd_nxt;
  logic                    oor_r, oor_nxt;

  gda_yctl_t               yctl;
  gda_ystat_t              ystat;

  logic [DOY_W-1:0]        alu_b;
  logic                    alu_sub;
  logic signed [TW-1:0]    alu_res;
  logic                    alu_neg;

  logic [DAY_W-1:0]        mlen;
  logic [DAY_W-1:0]        day_cl;
  logic [DOY_W-1:0]        doy;
  logic [DOY_W-1:0]        ylen;
  logic signed [TW-1:0]    off_ext;

  gda_year_ctr u_year (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (yctl),
    .stat  (ystat)
  );

  gda_alu #(.W(TW)) u_alu (
    .a   (t_r),
    .b   (alu_b),
    .sub (alu_sub),
    .res (alu_res),
    .neg (alu_neg)
  );

  // Month length serves both the day clamp and the month walk.
  assign mlen    = days_in(ystat.leap, mon_r);
  assign day_cl  = (day_r > mlen) ? mlen : day_r;
  assign doy     = month_start(mon_r) + {8'd0, (mon_r > MONTH_FEB) && ystat.leap}
                   + {4'd0, day_cl} - 9'd1;
  assign ylen    = YEAR_DAYS + {8'd0, ystat.leap};
  assign off_ext = $signed({{(TW-OFFSET_BITS){off_r[OFFSET_BITS-1]}}, off_r});

  always_comb begin
    state_nxt = state_r;
    mon_nxt   = mon_r;
    day_nxt   = day_r;
    off_nxt   = off_r;
    t_nxt     = t_r;
    valid_nxt = 1'b0;
    ry_nxt    = ry_r;
    rm_nxt    = rm_r;
    rd_nxt    = rd_r;
    oor_nxt   = oor_r;
    yctl      = '0;
    alu_b     = ylen;
    alu_sub   = 1'b1;

    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          // Clamp the start date fields; the day waits for the leap flag.
          yctl.load = 1'b1;
          if (in_start_year < YEAR_FIRST) begin
            yctl.year = YEAR_FIRST;
          end else if (in_start_year > YEAR_LAST) begin
            yctl.year = YEAR_LAST;
          end else begin
            yctl.year = in_start_year;
          end
          if (in_start_month < MONTH_JAN) begin
            mon_nxt = MONTH_JAN;
          end else if (in_start_month > MONTH_DEC) begin
            mon_nxt = MONTH_DEC;
          end else begin
            mon_nxt = in_start_month;
          end
          day_nxt   = (in_start_day < DAY_FIRST) ? DAY_FIRST : in_start_day;
          off_nxt   = in_day_offset;
          state_nxt = ST_SET1;
        end
      end
      // Let the year counter settle its century and remainder.
      ST_SET1: state_nxt = ST_SET2;
      ST_SET2: state_nxt = ST_DOY;
      ST_DOY: begin
        // Fold the offset into a day position relative to Jan 1 of the year.
        t_nxt     = $signed({{(TW-DOY_W){1'b0}}, doy}) + off_ext;
        state_nxt = ST_YEAR;
      end
      ST_YEAR: begin
        alu_b   = ylen;
        alu_sub = 1'b1;
        if (t_r[TW-1]) begin
          // Before Jan 1: drop back one year, then add its length.
          if (ystat.year == YEAR_FIRST) begin
            ry_nxt    = YEAR_FIRST;
            rm_nxt    = MONTH_JAN;
            rd_nxt    = DAY_FIRST;
            oor_nxt   = 1'b1;
            valid_nxt = 1'b1;
            state_nxt = ST_IDLE;
          end else begin
            yctl.dec  = 1'b1;
            state_nxt = ST_YADD;
          end
        end else if (!alu_neg) begin
          // Past the year end: skip the whole year forward.
          if (ystat.year == YEAR_LAST) begin
            ry_nxt    = YEAR_LAST;
            rm_nxt    = MONTH_DEC;
            rd_nxt    = DAY_LAST;
            oor_nxt   = 1'b1;
            valid_nxt = 1'b1;
            state_nxt = ST_IDLE;
          end else begin
            yctl.inc = 1'b1;
            t_nxt    = alu_res;
          end
        end else begin
          mon_nxt   = MONTH_JAN;
          state_nxt = ST_MONTH;
        end
      end
      ST_YADD: begin
        alu_b     = ylen;
        alu_sub   = 1'b0;
        t_nxt     = alu_res;
        state_nxt = ST_YEAR;
      end
      ST_MONTH: begin
        alu_b   = {4'd0, mlen};
        alu_sub = 1'b1;
        if ((mon_r < MONTH_DEC) && !alu_neg) begin
          // Skip the whole month.
          t_nxt   = alu_res;
          mon_nxt = mon_r + 4'd1;
        end else begin
          ry_nxt    = ystat.year;
          rm_nxt    = mon_r;
          rd_nxt    = t_r[DAY_W-1:0] + 5'd1;
          oor_nxt   = 1'b0;
          valid_nxt = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      valid_r <= valid_nxt;
    end
    mon_r <= mon_nxt;
    day_r <= day_nxt;
    off_r <= off_nxt;
    t_r   <= t_nxt;
    ry_r  <= ry_nxt;
    rm_r  <= rm_nxt;
    rd_r  <= rd_nxt;
    oor_r <= oor_nxt;
  end

  assign busy             = (state_r != ST_IDLE);
  assign out_valid        = valid_r;
  assign out_result_year  = ry_r;
  assign out_result_month = rm_r;
  assign out_result_day   = rd_r;
  assign out_out_of_range = oor_r;

endmodule

// ----- rtl/gda_alu.sv -----
// Shared add/subtract unit for year and month stepping.
`timescale 1ns / 1ps

module gda_alu
  import gda_pkg::*;
#(
  parameter int W = 18
) (
  input  logic signed [W-1:0] a,
  input  logic [DOY_W-1:0]    b,
  input  logic                sub,
  output logic signed [W-1:0] res,
  output logic                neg
);

  logic signed [W-1:0] b_ext;

  assign b_ext = $signed({{(W-DOY_W){1'b0}}, b});
  assign res   = sub ? (a - b_ext) : (a + b_ext);
  assign neg   = res[W-1];

endmodule

// ----- rtl/gda_year_ctr.sv -----
// Year counter that tracks year mod 100 and century to give the leap flag.
`timescale 1ns / 1ps

module gda_year_ctr
  import gda_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  gda_yctl_t  ctl,
  output gda_ystat_t stat
);

  localparam int          RECIP_SHIFT = 19;
  localparam logic [12:0] RECIP_100   = 13'd5243;
  localparam int          PROD_W      = YEAR_W + 13;
  localparam logic [6:0]  MOD_TOP     = 7'd99;

  logic [YEAR_W-1:0] year_r, year_nxt;
  logic [6:0]        cent_r, cent_nxt;
  logic [6:0]        mod_r, mod_nxt;
  logic [PROD_W-1:0] prod;
  logic [YEAR_W-1:0] cent_x100;
  logic [YEAR_W-1:0] rem_full;

  // Divide by 100 through the reciprocal; the remainder is taken from the registered quotient.
  assign prod      = {13'd0, year_r} * {{YEAR_W{1'b0}}, RECIP_100};
  assign cent_x100 = {7'd0, cent_r} * 14'd100;
  assign rem_full  = year_r - cent_x100;

  always_comb begin
    year_nxt = year_r;
    cent_nxt = prod[RECIP_SHIFT+6:RECIP_SHIFT];
    mod_nxt  = rem_full[6:0];
    if (ctl.load) begin
      year_nxt = ctl.year;
    end else if (ctl.inc) begin
      year_nxt = year_r + 14'd1;
      cent_nxt = (mod_r == MOD_TOP) ? cent_r + 7'd1 : cent_r;
      mod_nxt  = (mod_r == MOD_TOP) ? 7'd0 : mod_r + 7'd1;
    end else if (ctl.dec) begin
      year_nxt = year_r - 14'd1;
      cent_nxt = (mod_r == 7'd0) ? cent_r - 7'd1 : cent_r;
      mod_nxt  = (mod_r == 7'd0) ? MOD_TOP : mod_r - 7'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      year_r <= YEAR_FIRST;
      cent_r <= 7'd0;
      mod_r  <= 7'd1;
    end else begin
      year_r <= year_nxt;
      cent_r <= cent_nxt;
      mod_r  <= mod_nxt;
    end
  end

  assign stat.year = year_r;
  assign stat.leap = (year_r[1:0] == 2'b00) && ((mod_r != 7'd0) || (cent_r[1:0] == 2'b00));

endmodule
